// ----- sv/dpb_pkg.sv -----
// shared types and constants for the depth pixel back-projection block
`default_nettype none

package dpb_pkg;

    // image and field geometry
    localparam int MAX_DIM    = 4096;
    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 12;
    localparam int FOCAL_W    = 24;
    localparam int CENTER_W   = 20;
    localparam int FRAC_W     = 8;
    localparam int OUT_FRAC_W = 4;
    localparam int POINT_W    = 36;

    // datapath widths
    localparam int MAG_W  = CENTER_W;
    localparam int PROD_W = MAG_W + DEPTH_W;
    localparam int NUM_W  = PROD_W + OUT_FRAC_W;
    localparam int QUO_W  = POINT_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FOCAL_W;

    localparam logic [FOCAL_W-1:0]  FOCAL_X_RST  = 24'd153600;
    localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST  = 24'd153600;
    localparam logic [CENTER_W-1:0] CENTER_X_RST = 20'd81920;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 20'd61440;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 2'd0,
        CFG_FOCAL_Y  = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]  focal_x;
        logic [FOCAL_W-1:0]  focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
    } intrinsics_t;

    // one classified word waiting for the back end
    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ----- sv/dpb_front.sv -----
// front end: drops empty or out-of-frame samples and forms the centered offsets
`default_nettype none

module dpb_front (
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dpb_pkg::DEPTH_W-1:0]  depth,
    input  wire logic [dpb_pkg::COORD_W-1:0]  pixel_row,
    input  wire logic [dpb_pkg::COORD_W-1:0]  pixel_col,
    input  wire dpb_pkg::intrinsics_t         intr,
    input  wire dpb_pkg::queue_status_t       q_status,
    output logic                              push,
    output dpb_pkg::work_t                    push_item
);
    import dpb_pkg::*;

    logic             keep;
    logic [MAG_W:0]   off_x;
    logic [MAG_W:0]   off_y;

    // sign and magnitude of coord*256 - center
    function automatic logic [MAG_W:0] offset(input logic [COORD_W-1:0] coord,
                                              input logic [CENTER_W-1:0] center);
        logic [CENTER_W-1:0] pos;
        logic                neg;
        logic [MAG_W-1:0]    mag;
        pos = CENTER_W'({coord, {FRAC_W{1'b0}}});
        neg = pos < center;
        mag = neg ? (center - pos) : (pos - center);
        return {neg, mag};
    endfunction

    assign off_x = offset(pixel_col, intr.center_x);
    assign off_y = offset(pixel_row, intr.center_y);

    // classify: zero depth or coordinate outside the frame gives no word
    assign keep = (depth != '0) && (int'(pixel_row) < MAX_DIM) && (int'(pixel_col) < MAX_DIM);

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready && keep;

    assign push_item.mag_x = off_x[MAG_W-1:0];
    assign push_item.neg_x = off_x[MAG_W];
    assign push_item.mag_y = off_y[MAG_W-1:0];
    assign push_item.neg_y = off_y[MAG_W];
    assign push_item.depth = depth;

endmodule

`default_nettype wire

// ----- sv/dpb_queue.sv -----
// short fifo that decouples the front end from the arithmetic back end
`default_nettype none

module dpb_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire dpb_pkg::work_t         push_item,
    input  wire logic                   pop,
    output dpb_pkg::work_t              head,
    output dpb_pkg::queue_status_t      status
);
    import dpb_pkg::*;

    work_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- sv/dpb_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none

module dpb_div (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [dpb_pkg::NUM_W-1:0]   num,
    input  wire logic [dpb_pkg::FOCAL_W-1:0] den,
    output logic      [dpb_pkg::QUO_W-1:0]   quo,
    output logic                             ovf
);
    import dpb_pkg::*;

    localparam int TOP_W = NUM_W - QUO_W;

    logic [FOCAL_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0]   low_reg [QUO_W];
    logic [QUO_W-1:0]   quo_reg [QUO_W];
    logic               ovf_reg [QUO_W];

    logic [FOCAL_W-1:0] rem_in [QUO_W];
    logic [QUO_W-1:0]   low_in [QUO_W];
    logic [QUO_W-1:0]   quo_in [QUO_W];
    logic               ovf_in [QUO_W];

    // the bits above the quotient range decide overflow up front
    assign rem_in[0] = FOCAL_W'(num[NUM_W-1:QUO_W]);
    assign low_in[0] = num[QUO_W-1:0];
    assign quo_in[0] = '0;
    assign ovf_in[0] = (FOCAL_W'(num[NUM_W-1:NUM_W-TOP_W]) >= den);

    for (genvar k = 1; k < QUO_W; k++)
    begin : g_link
        assign rem_in[k] = rem_reg[k-1];
        assign low_in[k] = low_reg[k-1];
        assign quo_in[k] = quo_reg[k-1];
        assign ovf_in[k] = ovf_reg[k-1];
    end

    // one trial subtract per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [FOCAL_W:0]   trial;
        logic [FOCAL_W:0]   diff;
        logic               ge;
        logic [FOCAL_W-1:0] rem_next;

        assign trial    = {rem_in[k], low_in[k][QUO_W-1]};
        assign diff     = trial - {1'b0, den};
        assign ge       = (trial >= {1'b0, den});
        assign rem_next = ge ? diff[FOCAL_W-1:0] : trial[FOCAL_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_in[k][QUO_W-2:0], 1'b0};
                quo_reg[k] <= {quo_in[k][QUO_W-2:0], ge};
                ovf_reg[k] <= ovf_in[k];
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];
    assign ovf = ovf_reg[QUO_W-1];

endmodule

`default_nettype wire

// ----- sv/dpb_back.sv -----
// back end: depth multiply, two divider lanes, saturation and output register
`default_nettype none

module dpb_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dpb_pkg::intrinsics_t              intr,
    input  wire dpb_pkg::work_t                    head,
    input  wire dpb_pkg::queue_status_t            q_status,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [dpb_pkg::POINT_W-1:0]     point_x,
    output logic signed [dpb_pkg::POINT_W-1:0]     point_y,
    output logic        [dpb_pkg::DEPTH_W-1:0]     point_z
);
    import dpb_pkg::*;

    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic               zero_x;
        logic               zero_y;
        logic [DEPTH_W-1:0] depth;
    } side_t;

    logic                en;
    logic                mul_valid_reg;
    logic [PROD_W-1:0]   prod_x_reg;
    logic [PROD_W-1:0]   prod_y_reg;
    logic                mul_neg_x_reg;
    logic                mul_neg_y_reg;
    logic [DEPTH_W-1:0]  mul_depth_reg;
    side_t               side_next;
    side_t               side_reg [QUO_W];
    logic [QUO_W-1:0]    side_valid_reg;
    logic [QUO_W-1:0]    quo_x;
    logic [QUO_W-1:0]    quo_y;
    logic                ovf_x;
    logic                ovf_y;
    logic                out_valid_reg;
    logic [POINT_W-1:0]  point_x_reg;
    logic [POINT_W-1:0]  point_y_reg;
    logic [DEPTH_W-1:0]  point_z_reg;

    // clamp to the 36-bit signed range and apply the sign
    function automatic logic [POINT_W-1:0] saturate(input logic [QUO_W-1:0] q,
                                                    input logic ovf,
                                                    input logic zero,
                                                    input logic neg);
        logic [QUO_W-1:0] neg_lim;
        logic [QUO_W-1:0] pos_lim;
        logic [QUO_W-1:0] mag;
        neg_lim = {1'b1, {(QUO_W-1){1'b0}}};
        pos_lim = {1'b0, {(QUO_W-1){1'b1}}};
        priority if (zero)
        begin
            mag = '0;
        end
        else if (neg)
        begin
            mag = (ovf || q > neg_lim) ? neg_lim : q;
        end
        else
        begin
            mag = (ovf || q > pos_lim) ? pos_lim : q;
        end
        return neg ? POINT_W'({POINT_W{1'b0}} - mag) : POINT_W'(mag);
    endfunction

    // whole pipeline advances while the output register can take a word
    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !q_status.empty;

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= !q_status.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg    <= PROD_W'(head.mag_x) * PROD_W'(head.depth);
            prod_y_reg    <= PROD_W'(head.mag_y) * PROD_W'(head.depth);
            mul_neg_x_reg <= head.neg_x;
            mul_neg_y_reg <= head.neg_y;
            mul_depth_reg <= head.depth;
        end
    end

    // divider lanes: offset * depth * 16 / focal
    dpb_div u_div_x (
        .clk (clk),
        .en  (en),
        .num ({prod_x_reg, {OUT_FRAC_W{1'b0}}}),
        .den (intr.focal_x),
        .quo (quo_x),
        .ovf (ovf_x)
    );

    dpb_div u_div_y (
        .clk (clk),
        .en  (en),
        .num ({prod_y_reg, {OUT_FRAC_W{1'b0}}}),
        .den (intr.focal_y),
        .quo (quo_y),
        .ovf (ovf_y)
    );

    // sideband travels alongside the divider stages
    always_comb
    begin
        side_next.neg_x  = mul_neg_x_reg;
        side_next.neg_y  = mul_neg_y_reg;
        side_next.zero_x = (prod_x_reg == '0);
        side_next.zero_y = (prod_y_reg == '0);
        side_next.depth  = mul_depth_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_valid_reg <= '0;
        end
        else if (en)
        begin
            side_valid_reg <= {side_valid_reg[QUO_W-2:0], mul_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < QUO_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_valid_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_x_reg <= saturate(quo_x, ovf_x, side_reg[QUO_W-1].zero_x,
                                    side_reg[QUO_W-1].neg_x);
            point_y_reg <= saturate(quo_y, ovf_y, side_reg[QUO_W-1].zero_y,
                                    side_reg[QUO_W-1].neg_y);
            point_z_reg <= side_reg[QUO_W-1].depth;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign point_z   = point_z_reg;

endmodule

`default_nettype wire

// ----- sv/depth_pixel_backprojection.sv -----
// Depth pixel back-projection: turns each depth sample with its row and column into a
// 3-D point with the pinhole model, x = (col - cx) * z / fx, y = (row - cy) * z / fy,
// z = depth, x and y signed with 4 fraction bits, truncated toward zero and saturated.
// A zero depth produces no output word. The block takes one input word per clock and
// delivers one point per clock while the output side is ready; from input accept to
// output valid a word passes the queue, the multiply stage, the 36-stage restoring
// divider (one quotient bit per stage) and the output register. A 4-entry queue behind
// the input lets the input keep flowing while the output stalls, up to four words. The user
// must see that intrinsics are written through the configuration port only while no
// words are in flight; the block does not enforce this, and cfg_ready is always high.
`default_nettype none

module depth_pixel_backprojection (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [dpb_pkg::DEPTH_W-1:0] depth,
    input  wire logic        [dpb_pkg::COORD_W-1:0] pixel_row,
    input  wire logic        [dpb_pkg::COORD_W-1:0] pixel_col,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed      [dpb_pkg::POINT_W-1:0] point_x,
    output logic signed      [dpb_pkg::POINT_W-1:0] point_y,
    output logic             [dpb_pkg::DEPTH_W-1:0] point_z,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic     [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic     [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dpb_pkg::*;

    logic [FOCAL_W-1:0]  focal_x_reg;
    logic [FOCAL_W-1:0]  focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    intrinsics_t         intr;
    queue_status_t       q_status;
    logic                push;
    logic                pop;
    work_t               push_item;
    work_t               head;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_X_RST;
            focal_y_reg  <= FOCAL_Y_RST;
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FOCAL_X:  focal_x_reg  <= cfg_data[FOCAL_W-1:0];
                CFG_FOCAL_Y:  focal_y_reg  <= cfg_data[FOCAL_W-1:0];
                CFG_CENTER_X: center_x_reg <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_data[CENTER_W-1:0];
            endcase
        end
    end

    assign intr.focal_x  = focal_x_reg;
    assign intr.focal_y  = focal_y_reg;
    assign intr.center_x = center_x_reg;
    assign intr.center_y = center_y_reg;

    dpb_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .depth     (depth),
        .pixel_row (pixel_row),
        .pixel_col (pixel_col),
        .intr      (intr),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    dpb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    dpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .intr      (intr),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z)
    );

endmodule

`default_nettype wire

// ----- sv/dpb_check.sv -----
// port-level checks for the back-projection block, bound to the top level
`default_nettype none

module dpb_check (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_ready,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic signed [dpb_pkg::POINT_W-1:0] point_x,
    input  wire logic signed [dpb_pkg::POINT_W-1:0] point_y,
    input  wire logic        [dpb_pkg::DEPTH_W-1:0] point_z
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(point_z))
        else $error("output word changed while stalled");

    // zero-depth samples never reach the output
    a_z_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_z != '0)
        else $error("output word with zero depth");

    // a cycle with the output open always leaves room in the queue
    a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |=> in_ready)
        else $error("input stalled although the pipeline advanced");

endmodule

bind depth_pixel_backprojection dpb_check u_dpb_check (.*);

`default_nettype wire

// ----- verif/dpb_checker.sv -----
// checker for the depth pixel back-projection block: predicts each point and compares
module dpb_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic        [dpb_pkg::DEPTH_W-1:0] depth,
    input  wire logic        [dpb_pkg::COORD_W-1:0] pixel_row,
    input  wire logic        [dpb_pkg::COORD_W-1:0] pixel_col,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic signed [dpb_pkg::POINT_W-1:0] point_x,
    input  wire logic signed [dpb_pkg::POINT_W-1:0] point_y,
    input  wire logic        [dpb_pkg::DEPTH_W-1:0] point_z,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic     [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic     [dpb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                      fail_count,
    output int                                      points_due
);
    import dpb_pkg::*;

    localparam logic [63:0] POS_LIMIT = 64'h0000_0007_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h0000_0008_0000_0000;

    typedef struct {
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic [DEPTH_W-1:0] z;
    } backprojected_point_t;

    // intrinsics as the block should hold them
    logic [FOCAL_W-1:0]  focal_x;
    logic [FOCAL_W-1:0]  focal_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;

    backprojected_point_t expected_points[$];
    backprojected_point_t predicted;
    backprojected_point_t observed;

    initial fail_count = 0;
    initial points_due = 0;

    // one axis: (coord - center) * depth / focal, 4 fraction bits, toward zero, saturated
    function automatic logic [POINT_W-1:0] project_axis(
        input logic [COORD_W-1:0]  coord,
        input logic [CENTER_W-1:0] center,
        input logic [FOCAL_W-1:0]  focal,
        input logic [DEPTH_W-1:0]  z
    );
        logic [63:0] pos;
        logic [63:0] ctr;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] quo;
        logic        neg;
        pos = '0;
        pos[COORD_W-1:0] = coord;
        pos = pos << FRAC_W;
        ctr = '0;
        ctr[CENTER_W-1:0] = center;
        neg = pos < ctr;
        mag = neg ? ctr - pos : pos - ctr;
        num = mag * {48'd0, z};
        num = num << OUT_FRAC_W;
        // a zero focal length drives the coordinate to the extreme of its sign
        if (focal == '0)
            quo = (num != 64'd0) ? NEG_LIMIT : 64'd0;
        else
            quo = num / {40'd0, focal};
        if (neg)
        begin
            if (quo > NEG_LIMIT)
                quo = NEG_LIMIT;
            quo = 64'd0 - quo;
        end
        else if (quo > POS_LIMIT)
            quo = POS_LIMIT;
        return quo[POINT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x    <= FOCAL_X_RST;
            focal_y    <= FOCAL_Y_RST;
            center_x   <= CENTER_X_RST;
            center_y   <= CENTER_Y_RST;
            points_due <= 0;
            expected_points.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_FOCAL_X:  focal_x  <= cfg_data[FOCAL_W-1:0];
                    CFG_FOCAL_Y:  focal_y  <= cfg_data[FOCAL_W-1:0];
                    CFG_CENTER_X: center_x <= cfg_data[CENTER_W-1:0];
                    CFG_CENTER_Y: center_y <= cfg_data[CENTER_W-1:0];
                    default: ;
                endcase
            end

            // accepted sample word: zero depth or an off-image coordinate gives no point
            if (in_valid && in_ready && depth != '0 &&
                pixel_row < MAX_DIM && pixel_col < MAX_DIM)
            begin
                predicted.x = project_axis(pixel_col, center_x, focal_x, depth);
                predicted.y = project_axis(pixel_row, center_y, focal_y, depth);
                predicted.z = depth;
                expected_points.insert(expected_points.size(), predicted);
            end

            // accepted point word against the oldest prediction
            if (out_valid && out_ready)
            begin
                observed.x = point_x;
                observed.y = point_y;
                observed.z = point_z;
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected point: x=%0d y=%0d z=%0d",
                                 $signed(observed.x), $signed(observed.y), observed.z);
                end
                else
                begin
                    predicted = expected_points.pop_front();
                    if (observed.x !== predicted.x || observed.y !== predicted.y ||
                        observed.z !== predicted.z)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("point mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                     $signed(predicted.x), $signed(predicted.y), predicted.z,
                                     $signed(observed.x), $signed(observed.y), observed.z);
                    end
                end
            end

            points_due <= expected_points.size();
        end
    end

endmodule

// ----- verif/tb_depth_pixel_backprojection.sv -----
// testbench top for the depth pixel back-projection block: stimulus, flow control, verdict
module tb_depth_pixel_backprojection;
    import dpb_pkg::*;

    localparam int LATENCY_CYCLES   = 38;
    localparam int SETTLE_CYCLES    = LATENCY_CYCLES + 10;
    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 200;
    localparam int HOLD_PHASE       = 2;
    localparam int HOLD_BACKLOG     = 150;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [DEPTH_W-1:0]    depth     = '0;
    logic [COORD_W-1:0]    pixel_row = '0;
    logic [COORD_W-1:0]    pixel_col = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [DEPTH_W-1:0]    point_z;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int points_due;
    int idle_run = 0;
    bit hold_off_req = 1'b0;

    always #4 clk = ~clk;

    depth_pixel_backprojection uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .depth     (depth),
        .pixel_row (pixel_row),
        .pixel_col (pixel_col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dpb_checker point_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .depth      (depth),
        .pixel_row  (pixel_row),
        .pixel_col  (pixel_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .points_due (points_due)
    );

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_run = 0;
        else
        begin
            idle_run++;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("depth_pixel_backprojection test failed");
                $finish;
            end
        end
    end

    // sample word: valid stays high afterwards until the caller idles
    task automatic send_sample(input logic [DEPTH_W-1:0] d, input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col);
        in_valid  <= 1'b1;
        depth     <= d;
        pixel_row <= row;
        pixel_col <= col;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_points;
        in_valid <= 1'b0;
        @(posedge clk);
        while (points_due != 0)
            @(posedge clk);
    endtask

    // drain, then leave the pipe idle for a while
    task automatic settle;
        wait_for_points();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_intrinsics(input logic [CFG_DATA_W-1:0] fx, input logic [CFG_DATA_W-1:0] fy,
                                   input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy);
        settle();
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_focal;
        case ($urandom_range(0, 3))
            0:       return CFG_DATA_W'($urandom_range(1, 4095));
            1:       return CFG_DATA_W'($urandom_range(256, 24'hFFFFFF));
            default: return CFG_DATA_W'($urandom_range(256 * 200, 256 * 1500));
        endcase
    endfunction

    // upper bits of a center write fall outside the register and are dropped
    function automatic logic [CFG_DATA_W-1:0] pick_center;
        if ($urandom_range(0, 1) == 0)
            return CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
        return CFG_DATA_W'($urandom_range(0, 256 * 4095));
    endfunction

    function automatic logic [DEPTH_W-1:0] pick_depth;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DEPTH_W'($urandom_range(1, 15));
            default: return DEPTH_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return COORD_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic int pick_gap;
        case ($urandom_range(0, 9))
            0:       return $urandom_range(10, 40);
            1, 2:    return 0;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // receiver: ready pattern changes every so often, with one long hold-off on request
    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 7) != 0);
                    3:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int burst_left;
        int gap;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset intrinsics: corners, zero depth, zero offset at the principal point
        send_sample(16'd0, 12'd0, 12'd0);
        send_sample(16'd0, 12'd4095, 12'd4095);
        send_sample(16'hFFFF, 12'd0, 12'd0);
        send_sample(16'hFFFF, 12'd4095, 12'd4095);
        send_sample(16'd1, 12'd240, 12'd320);
        send_sample(16'd1, 12'd0, 12'd0);
        send_sample(16'hFFFF, 12'd240, 12'd4095);
        send_sample(16'hAAAA, 12'hAAA, 12'h555);
        send_sample(16'h5555, 12'h555, 12'hAAA);
        send_sample(16'd1000, 12'd100, 12'd100);

        // unit focal lengths: saturation toward both extremes
        load_intrinsics(24'd1, 24'd1, 24'd0, 24'h0FFFFF);
        send_sample(16'hFFFF, 12'd0, 12'd4095);
        send_sample(16'hFFFF, 12'd4095, 12'd0);
        send_sample(16'd1, 12'd1, 12'd1);
        send_sample(16'd0, 12'd7, 12'd9);

        // zero focal lengths: extremes by sign, zero offset stays zero
        // centers at column 100.0 and row 7.5
        load_intrinsics(24'd0, 24'd0, 24'd25600, 24'd1920);
        send_sample(16'd500, 12'd7, 12'd100);
        send_sample(16'd500, 12'd4095, 12'd4095);
        send_sample(16'd500, 12'd0, 12'd0);
        send_sample(16'd1, 12'd8, 12'd99);

        // largest focal lengths, center writes with every data bit set
        load_intrinsics(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(16'hFFFF, 12'd0, 12'd0);
        send_sample(16'hFFFF, 12'd4095, 12'd4095);
        send_sample(16'd1, 12'd4095, 12'd4095);

        // random intrinsics per phase, bursty sample stream
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_intrinsics(pick_focal(), pick_focal(), pick_center(), pick_center());
            burst_left = $urandom_range(1, 40);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // long output hold-off while the input keeps offering words
                if (p == HOLD_PHASE && i == 0)
                    hold_off_req = 1'b1;
                if (i == ITEMS_PER_PHASE / 2)
                    wait_for_points();
                send_sample(pick_depth(), pick_coord(), pick_coord());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap = pick_gap();
                    if (gap > 0 && !(p == HOLD_PHASE && i < HOLD_BACKLOG))
                        idle_input(gap);
                end
            end
        end

        settle();
        if (fail_count == 0 && points_due == 0)
            $display("depth_pixel_backprojection test passed");
        else
            $display("depth_pixel_backprojection test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dpb_pkg.sv
sv/dpb_front.sv
sv/dpb_queue.sv
sv/dpb_div.sv
sv/dpb_back.sv
sv/depth_pixel_backprojection.sv
sv/dpb_check.sv
verif/dpb_checker.sv
verif/tb_depth_pixel_backprojection.sv
